// ----- src/tts_pkg.sv -----
// Package: shared widths, states and helpers for the tridiagonal solver.
package tts_pkg;

  localparam int MaxRows   = 64;
  localparam int ValueW    = 32;
  localparam int FracBits  = 16;
  localparam int IdxW      = $clog2(MaxRows);
  localparam int CntW      = IdxW + 1;
  // Pivot and numerator: exact 32-bit minus (64-bit product >> 16).
  localparam int WideW     = 50;
  // Dividend: wide value shifted left by the fraction bits.
  localparam int DivW      = WideW + FracBits;
  localparam int DivCntW   = $clog2(DivW + 1);

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [IdxW-1:0]          idx_t;
  typedef logic [CntW-1:0]          cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_PREV,
    ST_MUL_S,
    ST_MUL_X,
    ST_DIV_S,
    ST_DIV_X,
    ST_STORE,
    ST_BK_RD,
    ST_BK_MUL,
    ST_BK_OUT,
    ST_BK_WAIT
  } state_t;

  // Divider control and status between sequencer and divider.
  typedef struct packed {
    logic  start;
  } div_ctrl_t;

  typedef struct packed {
    logic  busy;
    logic  done;
  } div_stat_t;

  // Saturate a wide signed value to the value width.
  function automatic value_t sat_wide(input logic signed [DivW-1:0] v);
    logic signed [DivW-1:0] hi;
    logic signed [DivW-1:0] lo;
    hi = DivW'({1'b0, {(ValueW-1){1'b1}}});
    lo = -hi - DivW'(1);
    if (v > hi) begin
      sat_wide = value_t'(hi);
    end else if (v < lo) begin
      sat_wide = value_t'(lo);
    end else begin
      sat_wide = value_t'(v);
    end
  endfunction

endpackage

// ----- src/tts_if.sv -----
// Interface: valid/ready channel carrying a payload of configurable type.
interface tts_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tts_div.sv -----
// Divider: restoring signed division, one quotient bit per cycle.
module tts_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tts_pkg::div_ctrl_t                 ctrl,
  input  logic signed [tts_pkg::DivW-1:0]    dividend,
  input  tts_pkg::wide_t                     divisor,
  output tts_pkg::div_stat_t                 stat,
  output logic signed [tts_pkg::DivW-1:0]    quotient
);

  logic [tts_pkg::DivW-1:0]    rem_r, rem_nxt;
  logic [tts_pkg::DivW-1:0]    quo_r, quo_nxt;
  logic [tts_pkg::DivW-1:0]    den_r, den_nxt;
  logic                        neg_r, neg_nxt;
  logic [tts_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tts_pkg::DivW:0]      trial;
  logic [tts_pkg::DivW-1:0]    shifted;
  logic [tts_pkg::DivW-1:0]    dvd_mag;
  logic [tts_pkg::DivW-1:0]    dvs_ext;

  // Shift one bit of the dividend in, subtract when it fits.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_mag  = dividend[tts_pkg::DivW-1] ? -dividend : dividend;
    dvs_ext  = tts_pkg::DivW'(divisor);
    shifted  = {rem_r[tts_pkg::DivW-2:0], quo_r[tts_pkg::DivW-1]};
    trial    = {1'b0, shifted} - {1'b0, den_r};
    if (ctrl.start) begin
      rem_nxt  = '0;
      quo_nxt  = dvd_mag;
      den_nxt  = dvs_ext[tts_pkg::DivW-1] ? -dvs_ext : dvs_ext;
      neg_nxt  = dividend[tts_pkg::DivW-1] ^ divisor[tts_pkg::WideW-1];
      cnt_nxt  = tts_pkg::DivCntW'(tts_pkg::DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[tts_pkg::DivW]) begin
        rem_nxt = trial[tts_pkg::DivW-1:0];
        quo_nxt = {quo_r[tts_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[tts_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - tts_pkg::DivCntW'(1);
      if (cnt_r == tts_pkg::DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = neg_r ? -quo_r : quo_r;

  // Done comes only out of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  // No restart while running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctrl.start) else $error("divider restarted while busy");
  // Busy ends with done.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r) else $error("busy fell without done");

endmodule

// ----- src/tridiagonal_thomas_solver.sv -----
// Top level: Thomas algorithm tridiagonal solver with sequencer and stores.
//
// Rows enter on the in_ channel, one request per row (Q16.16 coefficients,
// right-hand side and a last-row flag). Each row is eliminated at once:
// two products through the shared multiplier, then, unless the pivot is
// zero, two divisions through the shared one-bit-per-cycle divider;
// in_ready is low meanwhile. The row flagged last starts back
// substitution: one result request per row on the out_ channel,
// highest row first, each sent only after the previous one is taken.
// While results are being sent no row is accepted.
// A stalled receiver simply holds out_valid and the payload; nothing is
// lost. Rows beyond 64 are dropped, but a dropped last row still solves.
// A synchronous active-low reset returns the sequencer to idle and clears
// the row count and the singular flag; the stores need no clearing.
module tridiagonal_thomas_solver (
  input logic clk,
  input logic rst_n,
  tts_if.sink   in_ch,
  tts_if.source out_ch
);

  typedef struct packed {
    tts_pkg::value_t sub_diag;
    tts_pkg::value_t main_diag;
    tts_pkg::value_t super_diag;
    tts_pkg::value_t rhs_value;
    logic            last_row;
  } in_t;

  typedef struct packed {
    tts_pkg::value_t solution;
    tts_pkg::idx_t   row_index;
    logic            final_res;
    logic            singular;
  } out_t;

  in_t  in_d;
  in_t  row_in;
  out_t out_d;
  assign in_d = in_ch.data;

  tts_pkg::state_t state_r, state_nxt;
  tts_pkg::cnt_t   cnt_r, cnt_nxt;
  tts_pkg::idx_t   bi_r, bi_nxt;
  logic            sing_r, sing_nxt;
  in_t             row_r;
  logic            keep_r;
  tts_pkg::value_t ps_r, px_r, cur_r, nxt_x_r;
  tts_pkg::value_t s_res_r;
  tts_pkg::wide_t  piv_r, num_r;
  logic signed [2*tts_pkg::ValueW-1:0] prod_r;
  logic            ovalid_r;
  tts_pkg::value_t osol_r;
  tts_pkg::idx_t   oidx_r;
  logic            ofin_r, osing_r;

  tts_pkg::value_t s_mem [tts_pkg::MaxRows];
  tts_pkg::value_t x_mem [tts_pkg::MaxRows];
  tts_pkg::value_t s_rd_r, x_rd_r;

  tts_pkg::div_ctrl_t div_ctrl;
  tts_pkg::div_stat_t div_stat;
  logic signed [tts_pkg::DivW-1:0] div_dvd;
  logic signed [tts_pkg::DivW-1:0] div_q;

  // Shared multiplier operands.
  tts_pkg::value_t mul_a, mul_b;
  logic signed [2*tts_pkg::ValueW-1:0] mul_p;
  tts_pkg::wide_t prod_sh;

  logic in_fire, out_fire, row_zero, piv_zero;
  tts_pkg::idx_t wr_idx, rd_idx;
  tts_pkg::value_t back_val;
  logic signed [tts_pkg::DivW-1:0] back_wide;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign row_zero = (cnt_r == '0);
  assign piv_zero = (piv_r == '0);
  assign wr_idx   = cnt_r[tts_pkg::IdxW-1:0];
  assign mul_p    = mul_a * mul_b;
  // Arithmetic shift floors, as required.
  assign prod_sh  = tts_pkg::wide_t'(prod_r >>> tts_pkg::FracBits);

  // Drop the super-diagonal of the row flagged last.
  always_comb begin
    row_in = in_d;
    if (in_d.last_row) begin
      row_in.super_diag = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (cnt_r[tts_pkg::CntW-1]) begin
            state_nxt = in_d.last_row ? tts_pkg::ST_BK_RD : tts_pkg::ST_IDLE;
          end else begin
            state_nxt = tts_pkg::ST_RD_PREV;
          end
        end
      end
      tts_pkg::ST_RD_PREV: state_nxt = tts_pkg::ST_MUL_S;
      tts_pkg::ST_MUL_S:   state_nxt = tts_pkg::ST_MUL_X;
      tts_pkg::ST_MUL_X:   state_nxt = tts_pkg::ST_DIV_S;
      tts_pkg::ST_DIV_S: begin
        if (piv_zero) begin
          state_nxt = tts_pkg::ST_STORE;
        end else if (div_stat.done) begin
          state_nxt = tts_pkg::ST_DIV_X;
        end
      end
      tts_pkg::ST_DIV_X: begin
        if (div_stat.done) begin
          state_nxt = tts_pkg::ST_STORE;
        end
      end
      tts_pkg::ST_STORE: begin
        state_nxt = row_r.last_row ? tts_pkg::ST_BK_RD : tts_pkg::ST_IDLE;
      end
      tts_pkg::ST_BK_RD:  state_nxt = tts_pkg::ST_BK_MUL;
      tts_pkg::ST_BK_MUL: state_nxt = tts_pkg::ST_BK_OUT;
      tts_pkg::ST_BK_OUT: state_nxt = tts_pkg::ST_BK_WAIT;
      tts_pkg::ST_BK_WAIT: begin
        if (out_fire) begin
          state_nxt = (bi_r == '0) ? tts_pkg::ST_IDLE : tts_pkg::ST_BK_RD;
        end
      end
      default: state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cnt_nxt   = cnt_r;
    bi_nxt    = bi_r;
    sing_nxt  = sing_r;
    mul_a     = '0;
    mul_b     = '0;
    div_ctrl.start = 1'b0;
    div_dvd   = '0;
    rd_idx    = wr_idx - tts_pkg::IdxW'(1);
    back_wide = tts_pkg::DivW'(cur_r) - tts_pkg::DivW'(prod_sh);
    back_val  = tts_pkg::sat_wide(back_wide);
    case (state_r)
      tts_pkg::ST_IDLE: begin
        if (in_fire && cnt_r[tts_pkg::CntW-1] && in_d.last_row) begin
          bi_nxt = tts_pkg::IdxW'(tts_pkg::MaxRows - 1);
        end
      end
      tts_pkg::ST_MUL_S: begin
        mul_a = row_r.sub_diag;
        mul_b = ps_r;
      end
      tts_pkg::ST_MUL_X: begin
        mul_a = row_r.sub_diag;
        mul_b = px_r;
      end
      tts_pkg::ST_DIV_S: begin
        if (piv_zero) begin
          sing_nxt = 1'b1;
        end else if (!div_stat.busy && !div_stat.done) begin
          div_ctrl.start = 1'b1;
          div_dvd = tts_pkg::DivW'(row_r.super_diag) <<< tts_pkg::FracBits;
        end else if (div_stat.done) begin
          div_ctrl.start = 1'b1;
          div_dvd = tts_pkg::DivW'(num_r) <<< tts_pkg::FracBits;
        end
      end
      tts_pkg::ST_STORE: begin
        cnt_nxt = cnt_r + tts_pkg::CntW'(1);
        bi_nxt  = wr_idx;
      end
      tts_pkg::ST_BK_RD: begin
        rd_idx = bi_r;
      end
      tts_pkg::ST_BK_MUL: begin
        mul_a = s_rd_r;
        mul_b = nxt_x_r;
      end
      tts_pkg::ST_BK_WAIT: begin
        if (out_fire) begin
          if (bi_r == '0) begin
            cnt_nxt  = '0;
            sing_nxt = 1'b0;
          end else begin
            bi_nxt = bi_r - tts_pkg::IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  tts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (piv_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Stores: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == tts_pkg::ST_STORE) begin
      s_mem[wr_idx] <= s_res_r;
      x_mem[wr_idx] <= piv_zero ? '0 : tts_pkg::sat_wide(div_q);
    end else if (state_r == tts_pkg::ST_BK_OUT) begin
      x_mem[bi_r] <= cur_r;
    end
    s_rd_r <= s_mem[rd_idx];
    x_rd_r <= x_mem[rd_idx];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r  <= row_in;
      keep_r <= row_zero;
    end
    if (state_r == tts_pkg::ST_RD_PREV) begin
      ps_r <= keep_r ? '0 : s_rd_r;
      px_r <= keep_r ? '0 : x_rd_r;
      if (keep_r) begin
        row_r.sub_diag <= '0;
      end
    end
    prod_r <= mul_p;
    if (state_r == tts_pkg::ST_MUL_X) begin
      piv_r <= tts_pkg::wide_t'(row_r.main_diag) - prod_sh;
    end
    if (state_r == tts_pkg::ST_DIV_S) begin
      // Capture the numerator while the second product is still held.
      if (!div_stat.busy && !div_stat.done) begin
        num_r <= tts_pkg::wide_t'(row_r.rhs_value) - prod_sh;
      end
      if (piv_zero) begin
        s_res_r <= '0;
      end else if (div_stat.done) begin
        s_res_r <= tts_pkg::sat_wide(div_q);
      end
    end
    if (state_r == tts_pkg::ST_BK_MUL) begin
      // Top row keeps its partial value.
      cur_r <= x_rd_r;
    end
    if (state_r == tts_pkg::ST_BK_OUT) begin
      if (bi_r != tts_pkg::IdxW'(cnt_r - tts_pkg::CntW'(1))) begin
        cur_r <= back_val;
        osol_r <= back_val;
        nxt_x_r <= back_val;
      end else begin
        osol_r <= cur_r;
        nxt_x_r <= cur_r;
      end
      oidx_r  <= bi_r;
      ofin_r  <= (bi_r == '0);
      osing_r <= sing_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tts_pkg::ST_IDLE;
      cnt_r    <= '0;
      bi_r     <= '0;
      sing_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      bi_r     <= bi_nxt;
      sing_r   <= sing_nxt;
      if (state_r == tts_pkg::ST_BK_OUT) begin
        ovalid_r <= 1'b1;
      end else if (out_fire) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready       = (state_r == tts_pkg::ST_IDLE);
  assign out_d.solution    = osol_r;
  assign out_d.row_index   = oidx_r;
  assign out_d.final_res   = ofin_r;
  assign out_d.singular    = osing_r;
  assign out_ch.data       = out_d;
  assign out_ch.valid      = ovalid_r;

  // Row count never exceeds capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tts_pkg::CntW'(tts_pkg::MaxRows)) else $error("row count overflow");
  // Results only during back substitution.
  a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == tts_pkg::ST_BK_WAIT) else $error("stray result");
  // Final result clears the system.
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && ofin_r |=> cnt_r == '0 && !sing_r) else $error("no clear after run");
  // Input is refused while a row is in work.
  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_ch.ready) else $error("ready during division");

endmodule

// ----- verif/tridiagonal_thomas_solver_tb.sv -----
// Testbench: self-checking random and directed test of the tridiagonal solver.
`timescale 1ns / 1ps

module tridiagonal_thomas_solver_tb;

  typedef struct packed {
    tts_pkg::value_t sub_diag;
    tts_pkg::value_t main_diag;
    tts_pkg::value_t super_diag;
    tts_pkg::value_t rhs_value;
    logic            last_row;
  } row_t;

  typedef struct packed {
    tts_pkg::value_t solution;
    tts_pkg::idx_t   row_index;
    logic            final_res;
    logic            singular;
  } soln_t;

  localparam int RowTarget = 380;
  localparam int StallLimit = 4000;

  // Keeps its own copy of the elimination state and queues expected solutions.
  class thomas_scoreboard;
    longint norm_s[tts_pkg::MaxRows];
    longint part_x[tts_pkg::MaxRows];
    int     rows_held;
    bit     pivot_zero;
    soln_t  solutions_due[$];
    int     mismatches;
    int     solutions_seen;
    int     systems_solved;
    int     singular_systems;

    function new();
      rows_held = 0;
      pivot_zero = 0;
      mismatches = 0;
      solutions_seen = 0;
      systems_solved = 0;
      singular_systems = 0;
    endfunction

    // Clamp to the signed value width.
    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Exact product shifted down by the fraction bits, floor rounding.
    function longint qmul(longint p, longint q);
      return (p * q) >>> tts_pkg::FracBits;
    endfunction

    function void note_row(row_t r);
      longint a, b, c, f, prev_s, prev_x, piv, num, s, x;
      soln_t  e;
      a = longint'(r.sub_diag);
      b = longint'(r.main_diag);
      c = longint'(r.super_diag);
      f = longint'(r.rhs_value);
      prev_s = 0;
      prev_x = 0;
      // Eliminate the row unless the store is full.
      if (rows_held < tts_pkg::MaxRows) begin
        if (r.last_row) c = 0;
        if (rows_held == 0) begin
          a = 0;
        end else begin
          prev_s = norm_s[rows_held-1];
          prev_x = part_x[rows_held-1];
        end
        piv = b - qmul(a, prev_s);
        num = f - qmul(a, prev_x);
        if (piv == 0) begin
          pivot_zero = 1;
          s = 0;
          x = 0;
        end else begin
          s = clamp((c * 65536) / piv);
          x = clamp((num * 65536) / piv);
        end
        norm_s[rows_held] = s;
        part_x[rows_held] = x;
        rows_held++;
      end
      if (!r.last_row) return;
      // Back substitution, highest row first.
      for (int i = rows_held - 1; i >= 0; i--) begin
        if (i < rows_held - 1) part_x[i] = clamp(part_x[i] - qmul(norm_s[i], part_x[i+1]));
        e.solution  = tts_pkg::value_t'(part_x[i]);
        e.row_index = tts_pkg::idx_t'(i);
        e.final_res = (i == 0);
        e.singular  = pivot_zero;
        solutions_due.push_back(e);
      end
      systems_solved++;
      if (pivot_zero) singular_systems++;
      rows_held = 0;
      pivot_zero = 0;
    endfunction

    function void check_solution(soln_t got);
      soln_t e;
      solutions_seen++;
      if (solutions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected solution %p", got);
        return;
      end
      e = solutions_due.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp x=%0d row=%0d fin=%0b sing=%0b,",
                    " got x=%0d row=%0d fin=%0b sing=%0b"},
                   e.solution, e.row_index, e.final_res, e.singular,
                   got.solution, got.row_index, got.final_res, got.singular);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tts_if #(.payload_t(row_t))  in_ch ();
  tts_if #(.payload_t(soln_t)) out_ch ();

  tridiagonal_thomas_solver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  thomas_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  rows_sent;
  int  quiet_cycles;
  bit  draining_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Note accepted rows and check solutions at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_row(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_solution(out_ch.data);
  end

  // Stall the receiver at random.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no request accepted.
  always @(posedge clk) begin
    if (!rst_n || draining_done || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired, %0d solutions outstanding", sb.solutions_due.size());
      $display("tridiagonal_thomas_solver_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one row, idling first at random, and hold it until accepted.
  task automatic send_row(input row_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rows_sent++;
  endtask

  // Coefficient with a mix of tame, extreme and raw values.
  function automatic tts_pkg::value_t pick_coef(input int span);
    case ($urandom_range(9))
      0: return tts_pkg::value_t'($urandom);
      1: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      2: return '0;
      default: return tts_pkg::value_t'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Mostly diagonally dominant rows with random content.
  task automatic send_system(input int n_rows);
    row_t r;
    for (int i = 0; i < n_rows; i++) begin
      r.sub_diag   = pick_coef(32'h0001_0000);
      r.super_diag = pick_coef(32'h0001_0000);
      r.rhs_value  = pick_coef(32'h0010_0000);
      r.main_diag  = tts_pkg::value_t'($urandom_range(32'h0002_0000, 32'h0008_0000));
      if ($urandom_range(1)) r.main_diag = -r.main_diag;
      if ($urandom_range(19) == 0) r.main_diag = pick_coef(32'h7fff_ffff);
      // Zero pivot: nothing to eliminate and a zero diagonal.
      if ($urandom_range(29) == 0) begin
        r.sub_diag  = '0;
        r.main_diag = '0;
      end
      r.last_row = (i == n_rows - 1);
      send_row(r);
    end
  endtask

  task automatic send_fixed(input tts_pkg::value_t a, input tts_pkg::value_t b,
                            input tts_pkg::value_t c, input tts_pkg::value_t f,
                            input logic last);
    row_t r;
    r = '{sub_diag: a, main_diag: b, super_diag: c, rhs_value: f, last_row: last};
    send_row(r);
  endtask

  initial begin
    int n_rows;
    int systems;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 59;
    rows_sent = 0;
    quiet_cycles = 0;
    draining_done = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single row systems with fields at their extremes.
    send_fixed(32'sh7fffffff, 32'sh0001_0000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_fixed(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    send_fixed(32'sh7fffffff, 32'sh0000_0001, 32'sh0, 32'sh7fffffff, 1'b1);
    // Zero pivot on row 0 marks the whole system singular.
    send_fixed(32'sh0001_0000, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_fixed(32'sh0001_0000, 32'sh0002_0000, 32'sh0005_0000, 32'sh0003_0000, 1'b1);
    // Ignored row-0 sub-diagonal and last-row super-diagonal.
    send_fixed(32'sh7fff_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
    send_fixed(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0005_0000, 1'b0);
    send_fixed(32'sh0001_0000, 32'sh0004_0000, 32'sh7fff_0000, 32'sh0007_0000, 1'b1);
    // Pivot cancels exactly on row 1.
    send_fixed(32'sh0, 32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0);
    send_fixed(32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0001_0000, 1'b1);
    // Tiny pivot forces saturation of both quotients.
    send_fixed(32'sh0, 32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_fixed(32'sh7fffffff, 32'shffff_ffff, 32'sh0, 32'sh7fffffff, 1'b1);

    // Random systems in three idling phases; overflow past the store size too.
    systems = 0;
    while (rows_sent < RowTarget) begin
      if (rows_sent > 2 * RowTarget / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rows_sent > RowTarget / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 27;
      end
      case ($urandom_range(39))
        0: n_rows = tts_pkg::MaxRows;
        1: n_rows = tts_pkg::MaxRows + 2;
        default: n_rows = $urandom_range(1, 8);
      endcase
      if (systems == 5) n_rows = tts_pkg::MaxRows + 3;
      send_system(n_rows);
      systems++;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sb.solutions_due.size() != 0) @(posedge clk);
    draining_done = 1;
    repeat (200) @(posedge clk);

    $display("Covered %0d rows in %0d systems (%0d singular), %0d solutions checked.",
             rows_sent, sb.systems_solved, sb.singular_systems, sb.solutions_seen);
    $display("Idling: sender/receiver stalls both ways, then none; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.solutions_due.size() == 0 && sb.rows_held == 0) begin
      $display("tridiagonal_thomas_solver_tb: PASS");
    end else begin
      $display("tridiagonal_thomas_solver_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tts_pkg.sv
src/tts_if.sv
src/tts_div.sv
src/tridiagonal_thomas_solver.sv
verif/tridiagonal_thomas_solver_tb.sv
